// ===== rtl/hsdc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsdc_pkg
// Shared constants and types for the hash set distinct counter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsdc_pkg;

  // table geometry and word widths
  localparam int TABLE_SLOTS_DEF = 1024;
  localparam int VALUE_W         = 64;
  localparam int DCOUNT_W        = 11;
  localparam int QUEUE_DEPTH     = 2;   // power of two
  localparam int EPOCH_W         = 8;

  // golden-ratio hash multiplier
  localparam logic [VALUE_W-1:0] HASH_MULT = 64'h9E3779B97F4A7C15;

  // input word
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [DCOUNT_W-1:0] distinct_count;
    logic                table_full;
  } out_word_t;

  // status of the probe engine
  typedef struct packed {
    logic clearing;
    logic busy;
  } probe_stat_t;

endpackage

`default_nettype wire

// ===== rtl/hsdc_chan_if.sv =====
// ----------------------------------------------------------------------------
// hsdc_chan_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsdc_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== rtl/hsdc_fifo.sv =====
// ----------------------------------------------------------------------------
// hsdc_fifo
// Short register queue between the hashing front and the probe engine.
// ----------------------------------------------------------------------------
`default_nettype none

module hsdc_fifo import hsdc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  push_ready,
  input  wire logic             pop,
  output logic                  pop_valid,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign push_ready = (fill_r != CNT_W'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hsdc_front.sv =====
// ----------------------------------------------------------------------------
// hsdc_front
// Accepts input words, hashes each value to its home slot and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module hsdc_front import hsdc_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int SLOT_W      = $clog2(TABLE_SLOTS),
  parameter int ITEM_W      = SLOT_W + 1 + VALUE_W
) (
  hsdc_chan_if.sink          in_chan,
  output logic               q_push,
  output logic [ITEM_W-1:0]  q_push_data,
  input  wire logic          q_push_ready
);

  // only the low slot bits of the 64-bit product matter, and those depend
  // only on the low slot bits of both operands
  localparam logic [SLOT_W-1:0] MULT_LO = SLOT_W'(HASH_MULT);

  logic [SLOT_W-1:0] home_slot;

  // home slot hash
  assign home_slot = in_chan.data.value[SLOT_W-1:0] * MULT_LO;

  // queue entry: home slot, last flag, value
  assign q_push      = in_chan.valid;
  assign q_push_data = {home_slot, in_chan.data.last, in_chan.data.value};
  assign in_chan.ready = q_push_ready;

endmodule

`default_nettype wire

// ===== rtl/hsdc_probe.sv =====
// ----------------------------------------------------------------------------
// hsdc_probe
// Linear-probing engine: table memory, probe sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsdc_probe import hsdc_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int SLOT_W      = $clog2(TABLE_SLOTS),
  parameter int ITEM_W      = SLOT_W + 1 + VALUE_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire logic [ITEM_W-1:0] q_data,
  output logic                   q_pop,
  hsdc_chan_if.source            out_chan,
  output probe_stat_t            stat
);

  localparam int CNT_W   = SLOT_W + 1;
  localparam int ENTRY_W = EPOCH_W + VALUE_W;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
  localparam logic [SLOT_W-1:0]  SLOT_LAST   = SLOT_W'(TABLE_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_PROBE = 3'b100
  } state_t;

  // table memory: epoch tag over stored value
  logic [ENTRY_W-1:0] mem [TABLE_SLOTS];

  state_t             state_r, state_nxt;
  logic [SLOT_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [VALUE_W-1:0] cur_value_r, cur_value_nxt;
  logic               cur_last_r, cur_last_nxt;
  logic [SLOT_W-1:0]  probe_addr_r, probe_addr_nxt;
  logic [SLOT_W-1:0]  probe_cnt_r, probe_cnt_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               full_r, full_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;
  logic [ENTRY_W-1:0] rd_data_r;
  logic               fwd_valid_r;
  logic [ENTRY_W-1:0] fwd_data_r;

  logic [SLOT_W-1:0]  q_home;
  logic               q_last;
  logic [VALUE_W-1:0] q_value;
  logic [ENTRY_W-1:0] slot_data;
  logic               slot_empty, slot_match, wrapped, resolved;
  logic               out_free, finish, insert, advance, set_done, wrap_epoch;
  logic [CNT_W-1:0]   new_count;
  logic               new_full;
  logic               rd_en, wr_en;
  logic [SLOT_W-1:0]  rd_addr, wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  assign {q_home, q_last, q_value} = q_data;

  // slot compare, with bypass of a write to the slot just read
  assign slot_data  = fwd_valid_r ? fwd_data_r : rd_data_r;
  assign slot_empty = (slot_data[ENTRY_W-1 -: EPOCH_W] != epoch_r);
  assign slot_match = !slot_empty && (slot_data[VALUE_W-1:0] == cur_value_r);
  assign wrapped    = (probe_cnt_r == SLOT_LAST);
  assign resolved   = slot_empty || slot_match || wrapped;

  // item completion
  assign out_free   = !out_valid_r || out_chan.ready;
  assign finish     = (state_r == ST_PROBE) && resolved && (!cur_last_r || out_free);
  assign advance    = (state_r == ST_PROBE) && !resolved;
  assign insert     = finish && slot_empty;
  assign set_done   = finish && cur_last_r;
  assign wrap_epoch = set_done && (epoch_r == EPOCH_LAST);
  assign new_count  = count_r + CNT_W'(insert);
  assign new_full   = full_r || (finish && !slot_empty && !slot_match);

  // next item is taken as soon as the engine is free
  assign q_pop = q_valid && ((state_r == ST_IDLE) || (finish && !wrap_epoch));

  // memory ports
  assign rd_en   = q_pop || advance;
  assign rd_addr = q_pop ? q_home : (probe_addr_r + SLOT_W'(1));
  assign wr_en   = insert || (state_r == ST_CLEAR);
  assign wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : probe_addr_r;
  assign wr_data = (state_r == ST_CLEAR) ? '0 : {epoch_r, cur_value_r};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    epoch_nxt      = epoch_r;
    cur_value_nxt  = cur_value_r;
    cur_last_nxt   = cur_last_r;
    probe_addr_nxt = probe_addr_r;
    probe_cnt_nxt  = probe_cnt_r;
    count_nxt      = count_r;
    full_nxt       = full_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_data_nxt   = out_data_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + SLOT_W'(1);
        if (clr_addr_r == SLOT_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_pop) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (advance) begin
          probe_addr_nxt = probe_addr_r + SLOT_W'(1);
          probe_cnt_nxt  = probe_cnt_r + SLOT_W'(1);
        end else if (finish) begin
          count_nxt = new_count;
          full_nxt  = new_full;
          if (set_done) begin
            out_valid_nxt             = 1'b1;
            out_data_nxt.distinct_count = DCOUNT_W'(new_count);
            out_data_nxt.table_full   = new_full;
            count_nxt                 = '0;
            full_nxt                  = 1'b0;
            epoch_nxt                 = epoch_r + EPOCH_W'(1);
          end
          if (wrap_epoch) begin
            state_nxt    = ST_CLEAR;
            clr_addr_nxt = '0;
            epoch_nxt    = EPOCH_FIRST;
          end else if (!q_pop) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
    // load a newly popped item
    if (q_pop) begin
      cur_value_nxt  = q_value;
      cur_last_nxt   = q_last;
      probe_addr_nxt = q_home;
      probe_cnt_nxt  = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      epoch_r     <= EPOCH_FIRST;
      count_r     <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      epoch_r     <= epoch_nxt;
      count_r     <= count_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_value_r  <= cur_value_nxt;
    cur_last_r   <= cur_last_nxt;
    probe_addr_r <= probe_addr_nxt;
    probe_cnt_r  <= probe_cnt_nxt;
    out_data_r   <= out_data_nxt;
  end

  // table memory, read-first with registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // bypass when the next read hits the slot being written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (rd_en) begin
      fwd_valid_r <= insert && (rd_addr == probe_addr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= {epoch_r, cur_value_r};
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;
  assign stat.clearing  = (state_r == ST_CLEAR);
  assign stat.busy      = (state_r == ST_PROBE);

endmodule

`default_nettype wire

// ===== rtl/hash_set_distinct_counter.sv =====
// A word resolved at its home slot gives its result after the queue pop with table read,
// then the compare, with the result registered; each further probe adds a table read and compare.
// Throughput: up to one word per cycle while probes resolve at the home slot,
// since the next read overlaps the compare; a last word waits while a result is held.
// Reset: synchronous, active low; a clearing pass over all TABLE_SLOTS slots runs
// after reset and again after every 255 sets, while no item is taken.
// ----------------------------------------------------------------------------
// hash_set_distinct_counter
// Counts distinct 64-bit values per set with a linear-probing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_set_distinct_counter import hsdc_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hsdc_chan_if.sink   in_chan,
  hsdc_chan_if.source out_chan
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int ITEM_W = SLOT_W + 1 + VALUE_W;

  logic              q_push, q_push_ready;
  logic [ITEM_W-1:0] q_push_data;
  logic              q_valid, q_pop;
  logic [ITEM_W-1:0] q_data;
  probe_stat_t       stat;

  // hashing front
  hsdc_front #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W),
    .ITEM_W      (ITEM_W)
  ) u_front (
    .in_chan      (in_chan),
    .q_push       (q_push),
    .q_push_data  (q_push_data),
    .q_push_ready (q_push_ready)
  );

  // decoupling queue
  hsdc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  // probe engine
  hsdc_probe #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W),
    .ITEM_W      (ITEM_W)
  ) u_probe (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_chan (out_chan),
    .stat     (stat)
  );

`ifndef SYNTHESIS
  // no word leaves the queue during a clearing pass
  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !q_pop)
    else $error("queue popped during clearing pass");

  // the engine only takes a word that the queue holds
  a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // a result only appears after a probe finished
  a_result_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(stat.busy))
    else $error("result without a finished probe");
`endif

endmodule

`default_nettype wire
